### sv/embedding_bpr_sgd_engine_defines.svh
// ----------------------------------------------------------------------------
// Embedding engine assertion macros
// Shared same-cycle and next-cycle implication assertion forms on clk_i/rst_ni.
// ----------------------------------------------------------------------------
`ifndef EMBEDDING_BPR_SGD_ENGINE_DEFINES_SVH
`define EMBEDDING_BPR_SGD_ENGINE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define EBS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define EBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ebs_pkg.sv
// ----------------------------------------------------------------------------
// Embedding engine package
// Operation and status codes, fixed widths and the sigmoid sample table.
// ----------------------------------------------------------------------------
package ebs_pkg;

  // Fixed field widths
  localparam int W_W   = 24;  // weight, signed Q7.16
  localparam int VAL_W = 40;  // result value
  localparam int MA_W  = 44;  // shared multiplier, wide operand
  localparam int MB_W  = 26;  // shared multiplier, narrow operand
  localparam int MP_W  = MA_W + MB_W;

  // Operations
  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_PREDICT = 2'd2,
    OP_UPDATE  = 2'd3
  } op_e;

  // Result status
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_RANGE  = 2'd2
  } status_e;

  // Configuration register indexes
  localparam logic [1:0] REG_LEARN_RATE = 2'd0;
  localparam logic [1:0] REG_DECAY      = 2'd1;

  // Samples of 1/(1+exp(a)) at a = 0, 0.5, ... 8.0, Q0.16
  function automatic logic [15:0] sig_sample(input logic [4:0] idx);
    logic [15:0] s;
    case (idx)
      5'd0:    s = 16'd32768;
      5'd1:    s = 16'd24743;
      5'd2:    s = 16'd17625;
      5'd3:    s = 16'd11955;
      5'd4:    s = 16'd7812;
      5'd5:    s = 16'd4971;
      5'd6:    s = 16'd3108;
      5'd7:    s = 16'd1921;
      5'd8:    s = 16'd1179;
      5'd9:    s = 16'd720;
      5'd10:   s = 16'd439;
      5'd11:   s = 16'd267;
      5'd12:   s = 16'd162;
      5'd13:   s = 16'd98;
      5'd14:   s = 16'd60;
      5'd15:   s = 16'd36;
      5'd16:   s = 16'd22;
      default: s = 16'd22;
    endcase
    return s;
  endfunction

endpackage

### sv/embedding_bpr_sgd_engine.sv
// ----------------------------------------------------------------------------
// Embedding engine with pairwise-ranking SGD
// User and item embedding memories; weight access, score prediction and
// one SGD step, all on a single shared multiplier under a sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o | op, indexes, lane, weight_in
//  out     | output    | out_valid_o/out_ready_i | value_out, status
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// The length of each operation is set by the single memory port per
// table and by the one shared multiplier.
// Reset clears only control; the memories hold no reset value.
// One item at a time; a finished result waits in the output register while
// the next item is taken. Configuration is always accepted.
module embedding_bpr_sgd_engine
  import ebs_pkg::*;
#(
  parameter int LATENT_DIM = 16,
  parameter int USER_COUNT = 1024,
  parameter int ITEM_COUNT = 4096
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration writes
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_index_i,
  input  logic [15:0]             cfg_data_i,
  // input items
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              op_i,
  input  logic [9:0]              user_index_i,
  input  logic [11:0]             prev_item_index_i,
  input  logic [11:0]             target_item_i,
  input  logic [11:0]             negative_item_i,
  input  logic                    table_select_i,
  input  logic [11:0]             row_index_i,
  input  logic [3:0]              lane_index_i,
  input  logic signed [W_W-1:0]   weight_in_i,
  // results
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [VAL_W-1:0] value_out_o,
  output logic [1:0]              status_o
);

  `include "embedding_bpr_sgd_engine_defines.svh"

  localparam int UMEM_D = USER_COUNT * LATENT_DIM;
  localparam int IMEM_D = ITEM_COUNT * LATENT_DIM;
  localparam int UA_W   = (UMEM_D > 1) ? $clog2(UMEM_D) : 1;
  localparam int IA_W   = (IMEM_D > 1) ? $clog2(IMEM_D) : 1;
  localparam int LN_W   = (LATENT_DIM > 1) ? $clog2(LATENT_DIM) : 1;
  localparam int ACC_W  = 49 + LN_W;
  localparam int DIF_W  = ACC_W + 1;
  localparam int XW     = DIF_W - 15;
  localparam int EW     = (XW > VAL_W) ? XW : VAL_W;
  localparam logic signed [EW-1:0] VMAX = EW'(40'sh7F_FFFF_FFFF);
  localparam logic signed [EW-1:0] VMIN = EW'(40'sh80_0000_0000);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_RDWAIT,
    S_DOT_RD, S_DOT_RO, S_DOT_MUL, S_DOT_ACC,
    S_XCALC, S_SIG, S_SIG2,
    S_UPD_RD0, S_UPD_RD1, S_UPD_RD2, S_UPD_H, S_UPD_GH, S_UPD_GD,
    S_DEC_A, S_DEC_B, S_DEC_C, S_DEC_D,
    S_RESULT
  } state_e;

  typedef enum logic [1:0] {SL_T, SL_N, SL_U, SL_P} slot_e;

  state_e state_q;
  slot_e  slot_q;
  logic   pass_q;
  logic [LN_W-1:0] lane_q;
  logic   out_valid_q;
  logic signed [VAL_W-1:0] out_val_q;
  logic [1:0]  out_st_q;
  logic [15:0] lr_q, decay_q;

  // latched item
  op_e         op_q;
  logic [9:0]  u_q;
  logic [11:0] p_q, t_q, n_q, row_q;
  logic        sel_q;
  logic [3:0]  lane_in_q;
  logic signed [W_W-1:0] weight_q;

  // datapath registers
  logic signed [W_W:0]     h_q;
  logic signed [ACC_W-1:0] acc_q, dot_t_q;
  logic signed [XW-1:0]    x_q;
  logic signed [VAL_W-1:0] res_val_q;
  logic [1:0]              res_st_q;
  logic [15:0]             sbase_q;
  logic                    big_q, xneg_q;
  logic [16:0]             g_q;
  logic signed [W_W-1:0]   u0_q, t0_q, n0_q, p0_q, tnew_q, nnew_q;
  logic signed [MA_W-1:0]  gh_q, gd_q, inner_q;
  logic signed [MP_W-1:0]  prod_q;

  // memories
  logic [W_W-1:0] user_mem [UMEM_D];
  logic [W_W-1:0] item_mem [IMEM_D];
  logic [UA_W-1:0] u_addr;
  logic [IA_W-1:0] i_addr;
  logic            u_we, i_we;
  logic [W_W-1:0]  u_wdata, i_wdata;
  logic [W_W-1:0]  u_rdata_q, i_rdata_q;

  // combinational helpers
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [DIF_W:0]   diff_r;
  logic signed [XW-1:0]    x_new;
  logic signed [EW-1:0]    x_ext;
  logic signed [VAL_W-1:0] x_sat;
  logic [XW-1:0]           x_abs;
  logic [3:0]              seg;
  logic [15:0]             seg_hi, seg_lo;
  logic [16:0]             s_val;
  logic signed [W_W-1:0]   w_sel, wnew;
  logic signed [MA_W-1:0]  drv;
  logic signed [MP_W:0]    pr_rnd;
  logic signed [VAL_W-1:0] w_sum;
  logic                    range_bad;
  logic                    lane_last;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign value_out_o = out_val_q;
  assign status_o    = out_st_q;
  assign lane_last   = (lane_q == LN_W'(LATENT_DIM - 1));

  // range check of the latched item
  always_comb begin
    if (op_q == OP_WRITE || op_q == OP_READ) begin
      range_bad = (32'(lane_in_q) >= LATENT_DIM) ||
                  (sel_q ? (32'(row_q) >= ITEM_COUNT) : (32'(row_q) >= USER_COUNT));
    end else begin
      range_bad = (32'(u_q) >= USER_COUNT) || (32'(p_q) >= ITEM_COUNT) ||
                  (32'(t_q) >= ITEM_COUNT) ||
                  (op_q == OP_UPDATE && 32'(n_q) >= ITEM_COUNT);
    end
  end

  // score difference, rounded and saturated
  always_comb begin
    acc_next = acc_q + ACC_W'(prod_q);
    diff_r   = DIF_W'(dot_t_q) - DIF_W'(acc_q) + (DIF_W + 1)'(17'sd32768);
    x_new    = $signed(diff_r[DIF_W:16]);
    x_ext    = EW'(x_new);
    if (x_ext > VMAX)      x_sat = VMAX[VAL_W-1:0];
    else if (x_ext < VMIN) x_sat = VMIN[VAL_W-1:0];
    else                   x_sat = x_ext[VAL_W-1:0];
  end

  // sigmoid table lookup
  always_comb begin
    x_abs  = x_q[XW-1] ? XW'(-x_q) : XW'(x_q);
    seg    = x_abs[18:15];
    seg_hi = sig_sample({1'b0, seg});
    seg_lo = sig_sample({1'b0, seg} + 5'd1);
    s_val  = big_q ? 17'd22 : (17'(sbase_q) - 17'(prod_q[30:15]));
  end

  // weight under decay and its drive term
  always_comb begin
    unique case (slot_q)
      SL_T: begin w_sel = t0_q; drv = gh_q;  end
      SL_N: begin w_sel = n0_q; drv = -gh_q; end
      SL_U: begin w_sel = u0_q; drv = gd_q;  end
      SL_P: begin
        drv = gd_q;
        if (p_q == t_q)      w_sel = tnew_q;
        else if (p_q == n_q) w_sel = nnew_q;
        else                 w_sel = p0_q;
      end
      default: begin w_sel = t0_q; drv = gh_q; end
    endcase
    pr_rnd = {prod_q[MP_W-1], prod_q} + (MP_W + 1)'(33'sd2147483648);
    w_sum  = VAL_W'(w_sel) + VAL_W'($signed(pr_rnd[MP_W:32]));
    if (w_sum > 40'sd8388607)       wnew = 24'sh7F_FFFF;
    else if (w_sum < -40'sd8388608) wnew = 24'sh80_0000;
    else                            wnew = w_sum[W_W-1:0];
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_DOT_MUL: begin
        mul_a = MA_W'(h_q);
        mul_b = MB_W'($signed(i_rdata_q));
      end
      S_SIG: begin
        mul_a = MA_W'($signed({1'b0, seg_hi - seg_lo}));
        mul_b = MB_W'($signed({1'b0, x_abs[14:0]}));
      end
      S_UPD_GH: begin
        mul_a = MA_W'(h_q);
        mul_b = MB_W'($signed({1'b0, g_q}));
      end
      S_UPD_GD: begin
        mul_a = MA_W'(t0_q) - MA_W'(n0_q);
        mul_b = MB_W'($signed({1'b0, g_q}));
      end
      S_DEC_A: begin
        mul_a = MA_W'(w_sel);
        mul_b = MB_W'($signed({1'b0, decay_q}));
      end
      S_DEC_C: begin
        mul_a = inner_q;
        mul_b = MB_W'($signed({1'b0, lr_q}));
      end
      default: ;
    endcase
  end

  // memory address and write select
  always_comb begin
    u_addr  = UA_W'(32'(u_q) * LATENT_DIM + 32'(lane_q));
    i_addr  = IA_W'(32'(p_q) * LATENT_DIM + 32'(lane_q));
    u_we    = 1'b0;
    i_we    = 1'b0;
    u_wdata = wnew;
    i_wdata = wnew;
    unique case (state_q)
      S_CHECK: begin
        u_addr  = UA_W'(32'(row_q) * LATENT_DIM + 32'(lane_in_q));
        i_addr  = IA_W'(32'(row_q) * LATENT_DIM + 32'(lane_in_q));
        u_wdata = weight_q;
        i_wdata = weight_q;
        u_we    = (op_q == OP_WRITE) && !range_bad && !sel_q;
        i_we    = (op_q == OP_WRITE) && !range_bad && sel_q;
      end
      S_DOT_RO: i_addr = IA_W'(32'(pass_q ? n_q : t_q) * LATENT_DIM + 32'(lane_q));
      S_UPD_RD0: i_addr = IA_W'(32'(t_q) * LATENT_DIM + 32'(lane_q));
      S_UPD_RD1: i_addr = IA_W'(32'(n_q) * LATENT_DIM + 32'(lane_q));
      S_DEC_D: begin
        unique case (slot_q)
          SL_T:    i_addr = IA_W'(32'(t_q) * LATENT_DIM + 32'(lane_q));
          SL_N:    i_addr = IA_W'(32'(n_q) * LATENT_DIM + 32'(lane_q));
          default: ;
        endcase
        u_we = (slot_q == SL_U);
        i_we = (slot_q != SL_U);
      end
      default: ;
    endcase
  end

  // embedding memories, registered read
  always_ff @(posedge clk_i) begin
    if (u_we) user_mem[u_addr] <= u_wdata;
    u_rdata_q <= user_mem[u_addr];
  end

  always_ff @(posedge clk_i) begin
    if (i_we) item_mem[i_addr] <= i_wdata;
    i_rdata_q <= item_mem[i_addr];
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_valid_i && in_ready_o) begin
      op_q      <= op_e'(op_i);
      u_q       <= user_index_i;
      p_q       <= prev_item_index_i;
      t_q       <= target_item_i;
      n_q       <= negative_item_i;
      sel_q     <= table_select_i;
      row_q     <= row_index_i;
      lane_in_q <= lane_index_i;
      weight_q  <= weight_in_i;
    end
    unique case (state_q)
      S_CHECK: begin
        acc_q     <= '0;
        res_val_q <= '0;
        res_st_q  <= range_bad ? ST_RANGE :
                     (op_q == OP_UPDATE && n_q == t_q) ? ST_REJECT : ST_OK;
      end
      S_RDWAIT: res_val_q <= VAL_W'($signed(sel_q ? i_rdata_q : u_rdata_q));
      S_DOT_RO: h_q <= (W_W + 1)'($signed(u_rdata_q)) + (W_W + 1)'($signed(i_rdata_q));
      S_DOT_ACC: begin
        if (lane_last && !pass_q) begin
          dot_t_q <= acc_next;
          acc_q   <= '0;
        end else begin
          acc_q <= acc_next;
        end
      end
      S_XCALC: begin
        x_q       <= x_new;
        res_val_q <= x_sat;
      end
      S_SIG: begin
        sbase_q <= seg_hi;
        big_q   <= |x_abs[XW-1:19];
        xneg_q  <= x_q[XW-1];
      end
      S_SIG2: g_q <= xneg_q ? (17'd65536 - s_val) : s_val;
      S_UPD_RD1: begin
        u0_q <= $signed(u_rdata_q);
        t0_q <= $signed(i_rdata_q);
      end
      S_UPD_RD2: n0_q <= $signed(i_rdata_q);
      S_UPD_H: begin
        p0_q <= $signed(i_rdata_q);
        h_q  <= (W_W + 1)'(u0_q) + (W_W + 1)'($signed(i_rdata_q));
      end
      S_UPD_GD: gh_q <= prod_q[MA_W-1:0];
      S_DEC_A: if (slot_q == SL_T) gd_q <= prod_q[MA_W-1:0];
      S_DEC_B: inner_q <= drv - prod_q[MA_W-1:0];
      S_DEC_D: begin
        if (slot_q == SL_T) tnew_q <= wnew;
        if (slot_q == SL_N) nnew_q <= wnew;
      end
      default: ;
    endcase
  end

  // sequencer, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_q      <= SL_T;
      pass_q      <= 1'b0;
      lane_q      <= '0;
      out_valid_q <= 1'b0;
      out_val_q   <= '0;
      out_st_q    <= ST_OK;
      lr_q        <= 16'd655;
      decay_q     <= 16'd66;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_LEARN_RATE) lr_q <= cfg_data_i;
        if (cfg_index_i == REG_DECAY)      decay_q <= cfg_data_i;
      end
      // result state loads the output register itself
      if (out_valid_q && out_ready_i && state_q != S_RESULT) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_CHECK;
        S_CHECK: begin
          lane_q <= '0;
          pass_q <= 1'b0;
          slot_q <= SL_T;
          if (range_bad || op_q == OP_WRITE)          state_q <= S_RESULT;
          else if (op_q == OP_READ)                   state_q <= S_RDWAIT;
          else if (op_q == OP_UPDATE && n_q == t_q)   state_q <= S_RESULT;
          else                                        state_q <= S_DOT_RD;
        end
        S_RDWAIT:  state_q <= S_RESULT;
        S_DOT_RD:  state_q <= S_DOT_RO;
        S_DOT_RO:  state_q <= S_DOT_MUL;
        S_DOT_MUL: state_q <= S_DOT_ACC;
        S_DOT_ACC: begin
          if (lane_last) begin
            lane_q <= '0;
            if (!pass_q && op_q == OP_UPDATE) begin
              pass_q  <= 1'b1;
              state_q <= S_DOT_RD;
            end else begin
              state_q <= S_XCALC;
            end
          end else begin
            lane_q  <= lane_q + LN_W'(1);
            state_q <= S_DOT_RD;
          end
        end
        S_XCALC:   state_q <= (op_q == OP_PREDICT) ? S_RESULT : S_SIG;
        S_SIG:     state_q <= S_SIG2;
        S_SIG2:    state_q <= S_UPD_RD0;
        S_UPD_RD0: state_q <= S_UPD_RD1;
        S_UPD_RD1: state_q <= S_UPD_RD2;
        S_UPD_RD2: state_q <= S_UPD_H;
        S_UPD_H:   state_q <= S_UPD_GH;
        S_UPD_GH:  state_q <= S_UPD_GD;
        S_UPD_GD: begin
          slot_q  <= SL_T;
          state_q <= S_DEC_A;
        end
        S_DEC_A:   state_q <= S_DEC_B;
        S_DEC_B:   state_q <= S_DEC_C;
        S_DEC_C:   state_q <= S_DEC_D;
        S_DEC_D: begin
          if (slot_q == SL_P) begin
            slot_q <= SL_T;
            if (lane_last) begin
              state_q <= S_RESULT;
            end else begin
              lane_q  <= lane_q + LN_W'(1);
              state_q <= S_UPD_RD0;
            end
          end else begin
            slot_q  <= slot_e'(slot_q + 2'd1);
            state_q <= S_DEC_A;
          end
        end
        S_RESULT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_val_q   <= (res_st_q == ST_OK) ? res_val_q : '0;
            out_st_q    <= res_st_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // checks
  `EBS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "accepted while busy")
  `EBS_ASSERT_SAME(a_err_value_zero, out_valid_o && status_o != ST_OK, value_out_o == '0, "nonzero value on error")
  `EBS_ASSERT_SAME(a_gain_range, state_q == S_DEC_A, g_q <= 17'd65536, "gain out of range")
  `EBS_ASSERT_SAME(a_no_write_idle, state_q == S_IDLE, !u_we && !i_we, "memory write while idle")

endmodule
